FILE: sv/upd_pkg.sv
// shared types, character codes and the hex digit decoder for the url percent decoder
// no dependencies; every other file imports this package
package upd_pkg;

    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_PCT     = 8'h25;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_ZERO    = 8'h30;
    localparam logic [7:0] C_NINE    = 8'h39;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_F = 8'h66;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_F = 8'h46;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int MAX_OUT = 3;
    localparam int SUB_W   = $clog2(MAX_OUT + 1);

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [SUB_W-1:0]        count;
        logic                    last;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // {is_hex, nibble value}
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= C_ZERO && b <= C_NINE) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= C_LOWER_A && b <= C_LOWER_F) ||
                     (b >= C_UPPER_A && b <= C_UPPER_F)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

FILE: sv/upd_front.sv
// front end: takes input beats, tracks the escape phase and builds a bundle of up to three bytes
// depends on upd_pkg
module upd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] in_byte
    input  logic             i_s_tlast,   // in_last
    input  logic             i_q_full,
    output logic             o_push,
    output upd_pkg::t_bundle o_push_data
);
    import upd_pkg::*;

    logic [1:0]       r_phase;
    logic [7:0]       r_held;
    logic [1:0]       n_phase;
    logic [7:0]       n_held;
    logic [SUB_W-1:0] n_cnt;
    logic             redo;
    logic [4:0]       nib_in;
    logic [4:0]       nib_held;
    logic             accept;

    assign nib_in     = hex_nibble(i_s_tdata);
    assign nib_held   = hex_nibble(r_held);
    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_push_data.data = '0;
        n_cnt            = '0;
        n_phase          = r_phase;
        n_held           = r_held;
        redo             = 1'b0;
        case (r_phase)
            PH_PCT: begin
                if (nib_in[4]) begin
                    n_held  = i_s_tdata;
                    n_phase = PH_DIGIT;
                end else begin
                    o_push_data.data[n_cnt] = C_PCT;
                    n_cnt = n_cnt + 1'b1;
                    redo  = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (nib_in[4]) begin
                    o_push_data.data[n_cnt] = {nib_held[3:0], nib_in[3:0]};
                    n_cnt   = n_cnt + 1'b1;
                    n_phase = PH_IDLE;
                    n_held  = 8'd0;
                end else begin
                    o_push_data.data[n_cnt] = C_PCT;
                    n_cnt = n_cnt + 1'b1;
                    o_push_data.data[n_cnt] = r_held;
                    n_cnt  = n_cnt + 1'b1;
                    n_held = 8'd0;
                    redo   = 1'b1;
                end
            end
            default: begin
                redo = 1'b1;
            end
        endcase
        if (redo) begin
            n_phase = PH_IDLE;
            if (i_s_tdata == C_PLUS) begin
                o_push_data.data[n_cnt] = C_SPACE;
                n_cnt = n_cnt + 1'b1;
            end else if (i_s_tdata == C_PCT) begin
                n_phase = PH_PCT;
            end else begin
                o_push_data.data[n_cnt] = i_s_tdata;
                n_cnt = n_cnt + 1'b1;
            end
        end
        if (i_s_tlast) begin
            if (n_phase == PH_PCT) begin
                o_push_data.data[n_cnt] = C_PCT;
                n_cnt = n_cnt + 1'b1;
            end else if (n_phase == PH_DIGIT) begin
                o_push_data.data[n_cnt] = C_PCT;
                n_cnt = n_cnt + 1'b1;
                o_push_data.data[n_cnt] = n_held;
                n_cnt = n_cnt + 1'b1;
            end
            n_phase = PH_IDLE;
            n_held  = 8'd0;
        end
        o_push_data.count = n_cnt;
        o_push_data.last  = i_s_tlast;
    end

    assign o_push = accept && (n_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

FILE: sv/upd_queue.sv
// short bundle queue between the front end and the output serializer
// depends on upd_pkg
module upd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  upd_pkg::t_bundle i_push_data,
    input  logic             i_pop,
    output upd_pkg::t_bundle o_head,
    output upd_pkg::t_q_stat o_stat
);
    import upd_pkg::*;

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_cnt == Q_DEPTH[Q_AW:0]);
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

FILE: sv/upd_back.sv
// back end: walks the head bundle one byte a cycle into the output
// register while it is free or i_m_tready is high; depends on upd_pkg
module upd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  upd_pkg::t_bundle i_head,
    input  logic             i_q_empty,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tlast,   // run_end
    output logic [0:0]       o_m_tuser    // [0] string_end
);
    import upd_pkg::*;

    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             r_ouser;
    logic [SUB_W-1:0] r_sub;
    logic             load;
    logic             run_end;

    assign load    = (!r_ovalid || i_m_tready) && !i_q_empty;
    assign run_end = (r_sub == (i_head.count - 1'b1));
    assign o_pop   = load && run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_sub    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_sub    <= run_end ? '0 : r_sub + 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= i_head.data[r_sub];
            r_olast <= run_end;
            r_ouser <= run_end && i_head.last;
        end
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = r_obyte;
    assign o_m_tlast    = r_olast;
    assign o_m_tuser[0] = r_ouser;

`ifndef ASSERT_OFF
    a_head_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (i_head.count != '0) && (r_sub < i_head.count))
        else $error("head bundle index out of range");
    a_string_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ouser |-> r_olast)
        else $error("string end without run end");
    a_sub_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_sub == '0)
        else $error("byte index not cleared after pop");
`endif

endmodule

FILE: sv/url_percent_decoder_top.sv
// url percent decoder: form-urlencoded query string in, decoded bytes out
// usage notes below; depends on upd_pkg, upd_front, upd_queue, upd_back
//
// input stream: one encoded byte per beat on i_s_tdata, i_s_tlast on the final
// byte of a string. output stream: one decoded byte per beat on o_m_tdata,
// o_m_tlast on the last byte caused by one input beat, o_m_tuser[0] on the
// last byte of the whole string. an input beat gives zero to three output
// beats; a plus becomes a space and a percent escape becomes one byte, while a
// bad or cut off escape comes out as the literal characters.
// the edge that takes an input beat writes its bundle into the queue; the
// output register then loads the first byte from the queue head.
// throughput: one input beat per cycle as long as the queue has room; the
// output side moves one byte per cycle while i_m_tready is high, so beats
// that expand to two or three bytes are absorbed by the four-entry queue and
// then hold off o_s_tready. when the receiver drops i_m_tready the output
// register keeps its beat, the queue fills and o_s_tready falls when full.
// reset (synchronous, active low) empties the queue, clears the output valid
// and returns the escape tracker to idle with no held digit.
module url_percent_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // run_end
    output logic [0:0] o_m_tuser    // [0] string_end
);
    import upd_pkg::*;

    t_q_stat q_stat;
    t_bundle push_data;
    t_bundle head;
    logic    push;
    logic    pop;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    upd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_empty  (q_stat.empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
